// ----- sv/ssrl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrl_pkg
// Shared types and constants of the shaped slew-rate limiter.
// ----------------------------------------------------------------------------
package ssrl_pkg;

	// curve phase is Q0.22, curve values are Q0.16
	localparam int PH_BITS = 22;
	localparam logic [22:0] PH_ONE = 23'h400000;
	localparam logic [16:0] CV_ONE = 17'h10000;
	localparam int STEP_W = 23;
	localparam int OFFSET_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_ADDR_W = 2;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_RISE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FALL = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MODE = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 2'd3;

	// curve shapes
	localparam logic [1:0] MODE_LIN = 2'd0;
	localparam logic [1:0] MODE_LOG = 2'd1;
	localparam logic [1:0] MODE_EXP = 2'd2;
	localparam logic [1:0] MODE_COS = 2'd3;

	typedef struct packed {
		logic [STEP_W-1:0] rise;
		logic [STEP_W-1:0] fall;
		logic [1:0]        mode;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_PREP,
		S_DIV,
		S_SRCH_A,
		S_SRCH_R,
		S_SRCH_C,
		S_EVAL_A,
		S_EVAL_R,
		S_EVAL_M,
		S_FINAL
	} lane_st_t;

endpackage

// ----- sv/shaped_slew_rate_limiter_core.sv -----
// ----------------------------------------------------------------------------
// shaped_slew_rate_limiter_core
// Multi-channel shaped slew-rate limiter: one lane per channel, results
// merged into one output transaction per frame.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  s_*     | s_tvalid/s_tready  | s_tdata: one sample per channel
//  m_*     | m_tvalid/m_tready  | m_tdata: one output per channel
//  cfg_*   | cfg_valid/cfg_ready| cfg_addr register index, cfg_data value
//
// A lane that jumps or clamps linearly finishes after setup. A curve
// move runs prep, up to 16 division steps and a search over 23 phase
// bits (table read, interpolation, compare for each), then evaluation
// and the final level; the slowest lane sets the frame time, and the merge follows.
// Reset clears all channel state; the next input is taken once the frame's
// result sits in the output register, even while it waits downstream.
// ----------------------------------------------------------------------------
module shaped_slew_rate_limiter_core #(
	parameter int SAMPLE_BITS = 24,
	parameter int CURVE_TABLE_SIZE = 1024,
	parameter int CHANNELS = 3
) (
	input  logic clk,
	input  logic arst_n,
	// sample_mono, sample_left, sample_right, ... from the lowest bit up
	input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// out_mono, out_left, out_right, ... from the lowest bit up
	output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ssrl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ssrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int SUMW = ((SB > ssrl_pkg::OFFSET_W) ? SB : ssrl_pkg::OFFSET_W) + 1;

	ssrl_pkg::cfg_t cfg_q;
	logic signed [ssrl_pkg::OFFSET_W-1:0] offset_q;
	logic busy_q;
	logic in_acc, frame_done;
	logic [CHANNELS-1:0] lane_done;
	logic [CHANNELS*SB-1:0] lane_data;
	logic [ssrl_pkg::STEP_W-1:0] step_sat;

	assign cfg_ready = 1'b1;
	assign s_tready = !busy_q;
	assign in_acc = s_tvalid && s_tready;

	// step registers saturate at full scale
	always_comb begin
		step_sat = cfg_data[ssrl_pkg::STEP_W-1:0];
		if (step_sat > ssrl_pkg::PH_ONE) step_sat = ssrl_pkg::PH_ONE;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				ssrl_pkg::REG_RISE:   cfg_q.rise <= step_sat;
				ssrl_pkg::REG_FALL:   cfg_q.fall <= step_sat;
				ssrl_pkg::REG_MODE:   cfg_q.mode <= cfg_data[1:0];
				ssrl_pkg::REG_OFFSET: offset_q <= signed'(cfg_data[ssrl_pkg::OFFSET_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// frame in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (in_acc) busy_q <= 1'b1;
		else if (frame_done) busy_q <= 1'b0;
	end

	// one lane per channel, biased and saturated target
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic signed [SB-1:0] smp, tgt;
		logic signed [SUMW-1:0] sum;

		always_comb begin
			smp = signed'(s_tdata[c*SB +: SB]);
			sum = SUMW'(smp) + SUMW'(offset_q);
			if (sum > SUMW'(signed'({1'b0, {(SB-1){1'b1}}}))) tgt = {1'b0, {(SB-1){1'b1}}};
			else if (sum < SUMW'(signed'({1'b1, {(SB-1){1'b0}}})))
				tgt = {1'b1, {(SB-1){1'b0}}};
			else tgt = sum[SB-1:0];
		end

		ssrl_lane #(
			.SB(SB),
			.N(CURVE_TABLE_SIZE)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.start(in_acc),
			.target(tgt),
			.cfg(cfg_q),
			.done(lane_done[c]),
			.level(lane_data[c*SB +: SB])
		);
	end

	ssrl_merge #(
		.SB(SB),
		.CH(CHANNELS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.lane_done(lane_done),
		.lane_data(lane_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.frame_done(frame_done)
	);

endmodule

// ----- sv/ssrl_lane.sv -----
// ----------------------------------------------------------------------------
// ssrl_lane
// One channel of the limiter: jump, linear clamp, or curve phase recovery by
// division and bitwise search over the curve tables, then curve evaluation.
// ----------------------------------------------------------------------------
module ssrl_lane #(
	parameter int SB = 24,
	parameter int N = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [SB-1:0]  target,
	input  ssrl_pkg::cfg_t        cfg,
	output logic                  done,
	output logic signed [SB-1:0]  level
);

	localparam int DW = SB + 1;
	localparam int WW = ((DW > 24) ? DW : 24) + 1;
	localparam int AW = $clog2(N + 1);
	localparam int PW = ssrl_pkg::PH_BITS + AW;
	localparam int PH_BITS_W = ssrl_pkg::PH_BITS;

	typedef logic [16:0] tbl_t [0:N];

	// integer square root used while building the tables
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] w;
		r = '0;
		b = 64'd1 << 62;
		w = v;
		for (int k = 0; k < 32; k++) begin
			if (b > w) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (w >= r + b) begin
					w = w - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic logic [16:0] to_q16(input logic [63:0] v);
		logic [63:0] q;
		q = (v + 64'd8192) >> 14;
		return (q > 64'(ssrl_pkg::CV_ONE)) ? ssrl_pkg::CV_ONE : q[16:0];
	endfunction

	function automatic tbl_t tidy(input tbl_t t);
		tbl_t o;
		o = t;
		o[0] = '0;
		o[N] = ssrl_pkg::CV_ONE;
		for (int i = 1; i <= N; i++) begin
			if (o[i] < o[i-1]) o[i] = o[i-1];
		end
		return o;
	endfunction

	// curve table for one shape, worked out at elaboration
	function automatic tbl_t build_tbl(input logic [1:0] sel);
		tbl_t e;
		tbl_t g;
		tbl_t c;
		logic [63:0] x;
		logic [63:0] x3;
		logic [63:0] s;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		longint sn;
		for (int i = 0; i <= N; i++) begin
			x = (64'(i) << 30) / N;
			x3 = (((x * x) >> 30) * x) >> 30;
			s = isqrt64(x << 30);
			e[i] = to_q16((x3 * s) >> 30);
			a = (ssrl_pkg::HALF_PI_Q30 * 64'(i)) / N;
			a2 = (a * a) >> 30;
			term = a;
			sn = longint'(a);
			for (int k = 1; k <= 5; k++) begin
				term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1) sn = sn - longint'(term);
				else sn = sn + longint'(term);
			end
			if (sn < 0) sn = 0;
			if (sn > (longint'(1) << 30)) sn = longint'(1) << 30;
			c[i] = to_q16((64'(sn) * 64'(sn)) >> 30);
		end
		e = tidy(e);
		for (int i = 0; i <= N; i++) g[i] = ssrl_pkg::CV_ONE - e[N-i];
		g = tidy(g);
		c = tidy(c);
		case (sel)
			ssrl_pkg::MODE_LOG: return g;
			ssrl_pkg::MODE_EXP: return e;
			default:            return c;
		endcase
	endfunction

	localparam tbl_t TB_LOG = build_tbl(ssrl_pkg::MODE_LOG);
	localparam tbl_t TB_EXP = build_tbl(ssrl_pkg::MODE_EXP);
	localparam tbl_t TB_COS = build_tbl(ssrl_pkg::MODE_COS);

	ssrl_pkg::lane_st_t state_q, state_d;

	logic signed [SB-1:0] tgt_q, level_q, start_q;
	logic seen_q, moving_q, up_q, done_q;
	logic [ssrl_pkg::STEP_W-1:0] step_q;
	logic [DW-1:0] aspan_q;
	logic span_neg_q;
	logic [DW:0] rem_q;
	logic [4:0] cnt_q;
	logic [16:0] u_q;
	logic [22:0] t_q, cand_q;
	logic [4:0] b_q;
	logic skip_q, ovr_q;
	logic [PH_BITS_W-1:0] fr_q;
	logic [16:0] lo_q, hi_q;
	logic [38:0] prod_q;
	logic [DW+16:0] mag_q;

	// setup decode
	logic signed [DW-1:0] delta;
	logic dir_up;
	logic [ssrl_pkg::STEP_W-1:0] step_sel;
	logic signed [WW-1:0] delta_w, stp_w, mv_w, lin_w;
	logic signed [SB-1:0] lin_lvl;
	logic fin_setup, new_move;

	always_comb begin
		delta = DW'(tgt_q) - DW'(level_q);
		dir_up = ~delta[DW-1];
		step_sel = dir_up ? cfg.rise : cfg.fall;
		delta_w = WW'(delta);
		stp_w = signed'(WW'(step_sel));
		mv_w = delta_w;
		if (delta_w > stp_w) mv_w = stp_w;
		if (delta_w < -stp_w) mv_w = -stp_w;
		lin_w = WW'(level_q) + mv_w;
		lin_lvl = lin_w[SB-1:0];
		fin_setup = !seen_q || (step_sel == '0) || (cfg.mode == ssrl_pkg::MODE_LIN);
		new_move = !moving_q || (dir_up != up_q);
	end

	// prep decode: span, fraction numerator
	logic signed [DW-1:0] span, num;
	logic [DW-1:0] aspan, anum;
	logic zero_u;

	always_comb begin
		span = DW'(tgt_q) - DW'(start_q);
		num = DW'(level_q) - DW'(start_q);
		aspan = span[DW-1] ? DW'(-span) : DW'(span);
		anum = num[DW-1] ? DW'(-num) : DW'(num);
		zero_u = (num == '0) || (num[DW-1] != span[DW-1]);
	end

	// restoring division step
	logic [DW:0] rem2;
	logic rem_ge;

	always_comb begin
		rem2 = {rem_q[DW-1:0], 1'b0};
		rem_ge = rem2 >= {1'b0, aspan_q};
	end

	// curve lookup address
	logic [22:0] cand, ph;
	logic [PW-1:0] pos;
	logic [AW-1:0] idx, idx1;
	logic rom_en;

	always_comb begin
		cand = t_q | (23'd1 << b_q);
		ph = (state_q == ssrl_pkg::S_EVAL_A) ? t_q : cand;
		pos = PW'(ph[21:0]) * PW'(N);
		idx = pos[PW-1:ssrl_pkg::PH_BITS];
		idx1 = idx + AW'(1);
		rom_en = (state_q == ssrl_pkg::S_SRCH_A) || (state_q == ssrl_pkg::S_EVAL_A);
	end

	// table read, registered
	always_ff @(posedge clk) begin
		if (rom_en) begin
			case (cfg.mode)
				ssrl_pkg::MODE_LOG: begin
					lo_q <= TB_LOG[idx];
					hi_q <= TB_LOG[idx1];
				end
				ssrl_pkg::MODE_EXP: begin
					lo_q <= TB_EXP[idx];
					hi_q <= TB_EXP[idx1];
				end
				default: begin
					lo_q <= TB_COS[idx];
					hi_q <= TB_COS[idx1];
				end
			endcase
		end
	end

	// interpolated curve value and search decision
	logic [16:0] cv;
	logic take;
	logic [22:0] t_next;
	logic [23:0] ph_sum;
	logic ph_end;

	always_comb begin
		cv = ovr_q ? ssrl_pkg::CV_ONE : (lo_q + prod_q[38:22]);
		take = !skip_q && (cv <= u_q);
		t_next = take ? cand_q : t_q;
		ph_sum = {1'b0, t_next} + {1'b0, step_q};
		ph_end = ph_sum >= {1'b0, ssrl_pkg::PH_ONE};
	end

	// final output
	logic [DW:0] magv;
	logic signed [DW:0] nl, nl_fix;

	always_comb begin
		magv = mag_q[DW+16:16];
		nl = span_neg_q ? ((DW+1)'(start_q) - signed'(magv)) :
			((DW+1)'(start_q) + signed'(magv));
		nl_fix = nl;
		if (nl == (DW+1)'(level_q)) begin
			nl_fix = (tgt_q > level_q) ? ((DW+1)'(level_q) + (DW+1)'(1)) :
				((DW+1)'(level_q) - (DW+1)'(1));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssrl_pkg::S_IDLE:   if (start) state_d = ssrl_pkg::S_SETUP;
			ssrl_pkg::S_SETUP:  state_d = fin_setup ? ssrl_pkg::S_IDLE : ssrl_pkg::S_PREP;
			ssrl_pkg::S_PREP: begin
				if (span == '0) state_d = ssrl_pkg::S_IDLE;
				else if (zero_u || anum >= aspan) state_d = ssrl_pkg::S_SRCH_A;
				else state_d = ssrl_pkg::S_DIV;
			end
			ssrl_pkg::S_DIV:    if (cnt_q == 5'd1) state_d = ssrl_pkg::S_SRCH_A;
			ssrl_pkg::S_SRCH_A: state_d = ssrl_pkg::S_SRCH_R;
			ssrl_pkg::S_SRCH_R: state_d = ssrl_pkg::S_SRCH_C;
			ssrl_pkg::S_SRCH_C: begin
				if (b_q != '0) state_d = ssrl_pkg::S_SRCH_A;
				else if (ph_end) state_d = ssrl_pkg::S_IDLE;
				else state_d = ssrl_pkg::S_EVAL_A;
			end
			ssrl_pkg::S_EVAL_A: state_d = ssrl_pkg::S_EVAL_R;
			ssrl_pkg::S_EVAL_R: state_d = ssrl_pkg::S_EVAL_M;
			ssrl_pkg::S_EVAL_M: state_d = ssrl_pkg::S_FINAL;
			ssrl_pkg::S_FINAL:  state_d = ssrl_pkg::S_IDLE;
			default:            state_d = ssrl_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = done_q;
		level = level_q;
	end

	// control state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssrl_pkg::S_IDLE;
			seen_q <= 1'b0;
			moving_q <= 1'b0;
			up_q <= 1'b1;
			start_q <= '0;
			level_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q != ssrl_pkg::S_IDLE) && (state_d == ssrl_pkg::S_IDLE);
			case (state_q)
				ssrl_pkg::S_IDLE: begin
					if (start) tgt_q <= target;
				end
				ssrl_pkg::S_SETUP: begin
					step_q <= step_sel;
					if (!seen_q) begin
						seen_q <= 1'b1;
						up_q <= 1'b1;
						moving_q <= 1'b0;
						start_q <= tgt_q;
						level_q <= tgt_q;
					end else if (step_sel == '0) begin
						up_q <= dir_up;
						moving_q <= 1'b0;
						start_q <= tgt_q;
						level_q <= tgt_q;
					end else if (cfg.mode == ssrl_pkg::MODE_LIN) begin
						level_q <= lin_lvl;
						moving_q <= lin_lvl != tgt_q;
						up_q <= dir_up;
						if (lin_lvl == tgt_q) start_q <= lin_lvl;
					end else if (new_move) begin
						start_q <= level_q;
						up_q <= dir_up;
						moving_q <= 1'b1;
					end
				end
				ssrl_pkg::S_PREP: begin
					aspan_q <= aspan;
					span_neg_q <= span[DW-1];
					t_q <= '0;
					b_q <= 5'd22;
					u_q <= '0;
					rem_q <= {1'b0, anum};
					cnt_q <= 5'd16;
					if (span == '0) begin
						moving_q <= 1'b0;
						start_q <= tgt_q;
						level_q <= tgt_q;
					end else if (!zero_u && anum >= aspan) begin
						u_q <= ssrl_pkg::CV_ONE;
					end
				end
				ssrl_pkg::S_DIV: begin
					rem_q <= rem_ge ? (rem2 - {1'b0, aspan_q}) : rem2;
					u_q <= {u_q[15:0], rem_ge};
					cnt_q <= cnt_q - 5'd1;
				end
				ssrl_pkg::S_SRCH_A: begin
					cand_q <= cand;
					skip_q <= cand > ssrl_pkg::PH_ONE;
					ovr_q <= cand[22];
					fr_q <= pos[ssrl_pkg::PH_BITS-1:0];
				end
				ssrl_pkg::S_SRCH_R, ssrl_pkg::S_EVAL_R: begin
					prod_q <= 39'(hi_q - lo_q) * 39'(fr_q);
				end
				ssrl_pkg::S_SRCH_C: begin
					if (b_q != '0) begin
						t_q <= t_next;
						b_q <= b_q - 5'd1;
					end else if (ph_end) begin
						moving_q <= 1'b0;
						start_q <= tgt_q;
						level_q <= tgt_q;
					end else begin
						t_q <= ph_sum[22:0];
					end
				end
				ssrl_pkg::S_EVAL_A: begin
					ovr_q <= 1'b0;
					fr_q <= pos[ssrl_pkg::PH_BITS-1:0];
				end
				ssrl_pkg::S_EVAL_M: begin
					mag_q <= (DW+17)'(aspan_q) * (DW+17)'(cv);
				end
				ssrl_pkg::S_FINAL: begin
					level_q <= nl_fix[SB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ssrl_pkg::S_IDLE)
		else $error("lane started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ssrl_pkg::S_IDLE)
		else $error("lane done while still working");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssrl_pkg::S_SRCH_C) |-> u_q <= ssrl_pkg::CV_ONE)
		else $error("curve fraction out of range");

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssrl_pkg::S_IDLE && !start) |=> $stable(level_q))
		else $error("level moved while idle");

endmodule

// ----- sv/ssrl_merge.sv -----
// ----------------------------------------------------------------------------
// ssrl_merge
// Collects the lane results of one frame and holds them in the output
// register until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module ssrl_merge #(
	parameter int SB = 24,
	parameter int CH = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CH-1:0]         lane_done,
	input  logic [CH*SB-1:0]      lane_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((CH*SB+7)/8)*8-1:0] m_tdata,
	output logic                  frame_done
);

	localparam int DATA_W = ((CH * SB + 7) / 8) * 8;

	logic [CH-1:0] got_q;
	logic all_in, load;
	logic valid_q, fdone_q;
	logic [DATA_W-1:0] data_q;

	// all lanes finished and the output slot is free or being emptied
	always_comb begin
		all_in = &(got_q | lane_done);
		load = all_in && (!valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_q <= '0;
			valid_q <= 1'b0;
			fdone_q <= 1'b0;
		end else begin
			fdone_q <= load;
			if (load) begin
				got_q <= '0;
				valid_q <= 1'b1;
			end else begin
				got_q <= got_q | lane_done;
				if (m_tready) valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) data_q <= DATA_W'(lane_data);
	end

	assign m_tvalid = valid_q;
	assign m_tdata = data_q;
	assign frame_done = fdone_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams three-channel sample frames through the slew-rate limiter under
// many rate, shape and bias settings, with random stalls on both sides, and
// checks every output frame against a cycle-free model of the limiter.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NCH = 3;
	localparam int SW = 24;
	localparam int TBL_N = 1024;
	localparam int unsigned PHASE_FULL = 32'd4194304;
	localparam int unsigned CURVE_FULL = 32'd65536;
	localparam longint SMP_MAX = 64'sd8388607;
	localparam longint SMP_MIN = -64'sd8388608;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [71:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ssrl_pkg::CFG_ADDR_W-1:0] cfg_addr = ssrl_pkg::REG_RISE;
	logic [ssrl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	shaped_slew_rate_limiter_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// curve tables, Q0.16
	int unsigned exp_curve[0:TBL_N];
	int unsigned log_curve[0:TBL_N];
	int unsigned cos_curve[0:TBL_N];

	// limiter settings and per-channel state
	int unsigned rise_rate, fall_rate;
	logic [1:0] shape;
	longint bias;
	bit started[NCH], in_move[NCH], rising[NCH];
	longint move_origin[NCH], out_level[NCH];

	logic [71:0] frame_q[$];
	logic [71:0] out_frame_q[$];
	int errors = 0;
	int frames_in = 0;
	int frames_out = 0;
	int settings_n = 0;
	bit quiet = 1'b0;
	int hold_asks = 0;
	int hold_served = 0;
	int rx_hold = 0;
	int tx_gap = 0;
	longint cycles = 0;
	longint chan_keep[NCH];

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned round_q16(longint unsigned q30);
		longint unsigned q;
		q = (q30 + 8192) >> 14;
		return (q > CURVE_FULL) ? CURVE_FULL : 32'(q);
	endfunction

	// x^3.5, raised cosine, and the mirrored log shape
	function automatic void build_curves();
		longint unsigned x, x3, s, a, a2, term;
		longint sn;
		for (int i = 0; i <= TBL_N; i++) begin
			x = (longint'(i) << 30) / TBL_N;
			x3 = (((x * x) >> 30) * x) >> 30;
			s = int_sqrt(x << 30);
			exp_curve[i] = round_q16((x3 * s) >> 30);
			a = (ssrl_pkg::HALF_PI_Q30 * i) / TBL_N;
			a2 = (a * a) >> 30;
			term = a;
			sn = longint'(a);
			for (int k = 1; k <= 5; k++) begin
				term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1) sn -= longint'(term);
				else sn += longint'(term);
			end
			if (sn < 0) sn = 0;
			if (sn > (64'sd1 << 30)) sn = 64'sd1 << 30;
			cos_curve[i] = round_q16((longint'(sn) * longint'(sn)) >> 30);
		end
		exp_curve[0] = 0;
		exp_curve[TBL_N] = CURVE_FULL;
		for (int i = 1; i <= TBL_N; i++)
			if (exp_curve[i] < exp_curve[i-1]) exp_curve[i] = exp_curve[i-1];
		for (int i = 0; i <= TBL_N; i++)
			log_curve[i] = CURVE_FULL - exp_curve[TBL_N - i];
		log_curve[0] = 0;
		log_curve[TBL_N] = CURVE_FULL;
		cos_curve[0] = 0;
		cos_curve[TBL_N] = CURVE_FULL;
		for (int i = 1; i <= TBL_N; i++) begin
			if (log_curve[i] < log_curve[i-1]) log_curve[i] = log_curve[i-1];
			if (cos_curve[i] < cos_curve[i-1]) cos_curve[i] = cos_curve[i-1];
		end
	endfunction

	function automatic int unsigned curve_point(logic [1:0] m, int i);
		case (m)
			ssrl_pkg::MODE_LOG: return log_curve[i];
			ssrl_pkg::MODE_EXP: return exp_curve[i];
			default:            return cos_curve[i];
		endcase
	endfunction

	// interpolated curve value at a Q0.22 phase
	function automatic int unsigned curve_value(logic [1:0] m, int unsigned ph);
		longint unsigned pos, fr, lo_v, hi_v;
		int idx;
		if (ph >= PHASE_FULL) return curve_point(m, TBL_N);
		pos = longint'(ph) * TBL_N;
		idx = int'(pos >> 22);
		fr = pos & (PHASE_FULL - 1);
		if (idx >= TBL_N) return curve_point(m, TBL_N);
		lo_v = curve_point(m, idx);
		hi_v = curve_point(m, idx + 1);
		return 32'(lo_v + (((hi_v - lo_v) * fr) >> 22));
	endfunction

	// largest phase whose curve value does not exceed u
	function automatic int unsigned phase_for(logic [1:0] m, int unsigned u);
		int unsigned ph, cand;
		ph = 0;
		for (int b = 22; b >= 0; b--) begin
			cand = ph | (32'd1 << b);
			if (cand <= PHASE_FULL && curve_value(m, cand) <= u) ph = cand;
		end
		return ph;
	endfunction

	function automatic longint snap_to(int c, longint goal);
		in_move[c] = 1'b0;
		move_origin[c] = goal;
		out_level[c] = goal;
		return goal;
	endfunction

	// one sample of one channel toward its target
	function automatic longint slew_channel(int c, longint goal);
		longint delta, span, num, mag, nl, mv;
		longint unsigned u, aspan;
		bit dir_up;
		int unsigned rate, ph;
		if (!started[c]) begin
			started[c] = 1'b1;
			rising[c] = 1'b1;
			return snap_to(c, goal);
		end
		delta = goal - out_level[c];
		dir_up = delta >= 0;
		rate = dir_up ? rise_rate : fall_rate;
		if (rate == 0) begin
			rising[c] = dir_up;
			return snap_to(c, goal);
		end
		if (shape == ssrl_pkg::MODE_LIN) begin
			mv = delta;
			if (mv > longint'(rate)) mv = rate;
			if (mv < -longint'(rate)) mv = -longint'(rate);
			out_level[c] += mv;
			in_move[c] = out_level[c] != goal;
			rising[c] = dir_up;
			if (!in_move[c]) move_origin[c] = out_level[c];
			return out_level[c];
		end
		if (!in_move[c] || dir_up != rising[c]) begin
			move_origin[c] = out_level[c];
			rising[c] = dir_up;
			in_move[c] = 1'b1;
		end
		span = goal - move_origin[c];
		if (span == 0) return snap_to(c, goal);
		aspan = (span < 0) ? -span : span;
		num = out_level[c] - move_origin[c];
		if (num == 0 || ((num < 0) != (span < 0))) begin
			u = 0;
		end else begin
			u = (longint'((num < 0) ? -num : num) << 16) / aspan;
			if (u > CURVE_FULL) u = CURVE_FULL;
		end
		ph = phase_for(shape, 32'(u)) + rate;
		if (ph >= PHASE_FULL) return snap_to(c, goal);
		mag = (aspan * curve_value(shape, ph)) >> 16;
		nl = (span < 0) ? move_origin[c] - mag : move_origin[c] + mag;
		if (nl == out_level[c]) nl = out_level[c] + ((goal > out_level[c]) ? 1 : -1);
		out_level[c] = nl;
		return nl;
	endfunction

	function automatic logic [71:0] limit_frame(logic [71:0] din);
		logic [71:0] r;
		longint goal;
		r = '0;
		for (int c = 0; c < NCH; c++) begin
			goal = longint'($signed(din[c*SW +: SW])) + bias;
			if (goal > SMP_MAX) goal = SMP_MAX;
			if (goal < SMP_MIN) goal = SMP_MIN;
			r[c*SW +: SW] = SW'(slew_channel(c, goal));
		end
		return r;
	endfunction

	function automatic void apply_register(logic [ssrl_pkg::CFG_ADDR_W-1:0] a,
		logic [ssrl_pkg::CFG_DATA_W-1:0] d);
		int unsigned s;
		s = 32'(d[22:0]);
		if (s > PHASE_FULL) s = PHASE_FULL;
		case (a)
			ssrl_pkg::REG_RISE:   rise_rate = s;
			ssrl_pkg::REG_FALL:   fall_rate = s;
			ssrl_pkg::REG_MODE:   shape = d[1:0];
			ssrl_pkg::REG_OFFSET: bias = longint'($signed(d));
			default: ;
		endcase
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nv = s_tvalid;
			if (s_tvalid && s_tready) begin
				out_frame_q.push_back(limit_frame(s_tdata));
				frames_in++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (frame_q.size() != 0) begin
					if (!quiet && $urandom_range(0, 7) == 0) begin
						tx_gap = $urandom_range(1, 19) - 1;
					end else begin
						s_tdata <= frame_q.pop_front();
						nv = 1'b1;
					end
				end
			end
			s_tvalid <= nv;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		logic [71:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				frames_out++;
				if (out_frame_q.size() == 0) begin
					errors++;
					$display("%t unexpected output transaction %h", $realtime, m_tdata);
				end else begin
					want = out_frame_q.pop_front();
					for (int c = 0; c < NCH; c++)
						if (m_tdata[c*SW +: SW] !== want[c*SW +: SW]) begin
							errors++;
							$display("%t channel %0d mismatch: expected %h actual %h",
								$realtime, c, want[c*SW +: SW], m_tdata[c*SW +: SW]);
						end
				end
			end
			if (hold_asks != hold_served) begin
				hold_served++;
				rx_hold = 400;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				rx_hold = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d output frames outstanding", out_frame_q.size());
			$display("shaped_slew_rate_limiter_core test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [ssrl_pkg::CFG_ADDR_W-1:0] a,
		logic [ssrl_pkg::CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_register(a, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limiter(logic [ssrl_pkg::CFG_DATA_W-1:0] r,
		logic [ssrl_pkg::CFG_DATA_W-1:0] f,
		logic [1:0] m, logic [ssrl_pkg::CFG_DATA_W-1:0] o);
		write_reg(ssrl_pkg::REG_RISE, r);
		write_reg(ssrl_pkg::REG_FALL, f);
		write_reg(ssrl_pkg::REG_MODE, {22'd0, m});
		write_reg(ssrl_pkg::REG_OFFSET, o);
		settings_n++;
	endtask

	task automatic drain();
		wait (frame_q.size() == 0 && !s_tvalid && out_frame_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_frame(longint a, longint b, longint c);
		frame_q.push_back({c[23:0], b[23:0], a[23:0]});
	endfunction

	function automatic logic [ssrl_pkg::CFG_DATA_W-1:0] pick_rate();
		case ($urandom_range(0, 6))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'd4194304;
			3: return {$urandom_range(0, 1) == 1, 23'($urandom_range(4194305, 8388607))};
			4: return 24'($urandom_range(1, 5000));
			5: return 24'($urandom_range(20000, 400000));
			default: return 24'($urandom_range(1, 4194304));
		endcase
	endfunction

	function automatic longint pick_sample();
		case ($urandom_range(0, 5))
			0: return SMP_MAX;
			1: return SMP_MIN;
			default: return longint'($signed(24'($urandom)));
		endcase
	endfunction

	// random frames: mostly held targets so moves play out, some noise
	function automatic void push_random_frame();
		if ($urandom_range(0, 9) == 0) begin
			push_frame(pick_sample(), pick_sample(), pick_sample());
		end else begin
			for (int c = 0; c < NCH; c++)
				if ($urandom_range(0, 4) == 0) chan_keep[c] = pick_sample();
			push_frame(chan_keep[0], chan_keep[1], chan_keep[2]);
		end
	endfunction

	initial begin
		logic [ssrl_pkg::CFG_DATA_W-1:0] ofs;
		build_curves();
		rise_rate = 0;
		fall_rate = 0;
		shape = ssrl_pkg::MODE_LIN;
		bias = 0;
		for (int c = 0; c < NCH; c++) begin
			started[c] = 1'b0;
			in_move[c] = 1'b0;
			rising[c] = 1'b1;
			move_origin[c] = 0;
			out_level[c] = 0;
			chan_keep[c] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first sample passes, zero rate jumps
		push_frame(0, 0, 0);
		push_frame(SMP_MAX, SMP_MIN, -1);
		push_frame(SMP_MIN, SMP_MAX, 1);
		drain();

		// bias saturation at both ends
		set_limiter(24'd0, 24'd0, ssrl_pkg::MODE_LIN, 24'h7FFFFF);
		push_frame(SMP_MAX, 1, SMP_MIN);
		drain();
		set_limiter(24'd0, 24'd0, ssrl_pkg::MODE_LIN, 24'h800000);
		push_frame(SMP_MIN, -1, SMP_MAX);
		drain();

		// linear clamp, settling, direction change
		set_limiter(24'd1000, 24'd3000000, ssrl_pkg::MODE_LIN, 24'd0);
		push_frame(SMP_MAX, SMP_MIN, 5);
		push_frame(SMP_MAX, SMP_MIN, 5);
		push_frame(SMP_MIN, SMP_MAX, 5);
		push_frame(SMP_MIN, SMP_MAX, 5);
		drain();

		// each curve shape: moves, reversal, held target, phase end
		for (int m = 1; m <= 3; m++) begin
			set_limiter(24'd1048576, 24'd1500000, m[1:0], 24'd0);
			push_frame(SMP_MAX, SMP_MIN, 12345);
			push_frame(SMP_MAX, SMP_MIN, 12345);
			push_frame(SMP_MIN, SMP_MAX, 12345);
			push_frame(SMP_MIN, SMP_MAX, -7);
			drain();
		end
		set_limiter(24'd4194304, 24'd8388607, ssrl_pkg::MODE_COS, 24'd0);
		push_frame(SMP_MAX, SMP_MIN, 0);
		push_frame(SMP_MIN, SMP_MAX, 0);
		drain();

		// random settings, each followed by a burst of frames
		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 5))
				0: ofs = 24'h7FFFFF;
				1: ofs = 24'h800000;
				2: ofs = 24'($urandom);
				default: ofs = 24'($signed($urandom_range(0, 2000)) - 1000);
			endcase
			set_limiter(pick_rate(), pick_rate(), p[1:0], ofs);
			if (p == 11) quiet = 1'b1;
			if (p == 3) hold_asks++;
			for (int i = 0; i < 90; i++) push_random_frame();
			drain();
		end

		$display("%0d frames sent, %0d checked across %0d limiter settings", frames_in,
			frames_out, settings_n);
		$display("covered all shapes, rate extremes, bias saturation and long output stalls");
		if (errors == 0 && out_frame_q.size() == 0)
			$display("shaped_slew_rate_limiter_core test passed");
		else
			$display("shaped_slew_rate_limiter_core test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/ssrl_pkg.sv
sv/ssrl_lane.sv
sv/ssrl_merge.sv
sv/shaped_slew_rate_limiter_core.sv
sim/testbench.sv
